[src/assert_macros.svh]
// Concurrent check helpers; each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

[src/ttw_pkg.sv]
package ttw_pkg;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_SET   = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_PUT       = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_TAB       = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_SET       = 3'd5,
    OP_READ      = 3'd6
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] char_code;
    logic [4:0] row_in;
    logic [6:0] col_in;
  } op_t;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [1:0] TAB_EXTRA    = 2'd3;

  localparam logic [7:0] TEXT_COLOR_RESET = 8'd15;
  localparam logic       REG_TEXT_COLOR   = 1'b0;

endpackage

[src/text_mode_terminal_writer.sv]
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   cmd, char_code, row_in, col_in
// out       output     out_valid/out_stall cursor_row_out, cursor_col_out, cell_value, scrolled
// cfg       input      APB, pready high    text_color at byte address 0
// Put, newline, backspace and set cursor pass S_IDLE, S_EXEC and S_DONE in the back
// sequencer, read cell adds S_READ, and tab runs S_EXEC once per space; cell writes pass at
// most one per cycle through a single-write RAM port. A scroll copies rows up in S_SCROLL and
// S_FLUSH, then blanks the last row in S_FILL; clear blanks every cell in S_FILL. A two-word
// queue takes words while the back end works; in_stall rises once it holds two. Reset homes
// the cursor; the cell store holds no valid data until cleared or written. out_stall holds
// the result register and backs up the queue.
module text_mode_terminal_writer #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  char_code,
  input  logic [4:0]  row_in,
  input  logic [6:0]  col_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  cursor_row_out,
  output logic [6:0]  cursor_col_out,
  output logic [15:0] cell_value,
  output logic        scrolled,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  logic         q_valid;
  logic         q_pop;
  ttw_pkg::op_t q_word;
  logic [7:0]   text_color;
  logic         reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == ttw_pkg::REG_TEXT_COLOR);
  assign prdata  = reg_hit ? {24'd0, text_color} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= ttw_pkg::TEXT_COLOR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      text_color <= pwdata[7:0];
    end
  end

  ttw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .char_code (char_code),
    .row_in    (row_in),
    .col_in    (col_in),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop)
  );

  ttw_back #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .text_color     (text_color),
    .q_valid        (q_valid),
    .q_word         (q_word),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cell_value     (cell_value),
    .scrolled       (scrolled)
  );

  `ASSERT_IMPL(a_pop_nonempty, q_pop, q_valid, "pop from empty queue")
  `ASSERT_IMPL(a_cursor_range, out_valid, (int'(cursor_col_out) < SCREEN_COLS), "cursor column out of range")
  `ASSERT_IMPL(a_scroll_last_row, out_valid && scrolled, (cursor_row_out == 5'(SCREEN_ROWS - 1)), "scroll left cursor off last row")
  `ASSERT_NEVER(a_pop_while_busy_out, q_pop && in_stall && !q_valid, "queue full but empty")

endmodule

[src/ttw_ram.sv]
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/ttw_front.sv]
module ttw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     cmd,
  input  logic [7:0]     char_code,
  input  logic [4:0]     row_in,
  input  logic [6:0]     col_in,
  output logic           q_valid,
  output ttw_pkg::op_t   q_word,
  input  logic           q_pop
);

  ttw_pkg::op_t q_mem [2];
  ttw_pkg::op_t op_new;
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;

  always_comb begin
    op_new.char_code = char_code;
    op_new.row_in    = row_in;
    op_new.col_in    = col_in;
    case (cmd)
      ttw_pkg::CMD_PUT: begin
        if (char_code == ttw_pkg::CH_NEWLINE) begin
          op_new.kind = ttw_pkg::OP_NEWLINE;
        end else if (char_code == ttw_pkg::CH_BACKSPACE) begin
          op_new.kind = ttw_pkg::OP_BACKSPACE;
        end else if (char_code == ttw_pkg::CH_TAB) begin
          op_new.kind = ttw_pkg::OP_TAB;
        end else begin
          op_new.kind = ttw_pkg::OP_PUT;
        end
      end
      ttw_pkg::CMD_CLEAR: op_new.kind = ttw_pkg::OP_CLEAR;
      ttw_pkg::CMD_SET:   op_new.kind = ttw_pkg::OP_SET;
      default:            op_new.kind = ttw_pkg::OP_READ;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_word   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= op_new;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[src/ttw_back.sv]
module ttw_back #(
  parameter int SCREEN_ROWS = 25,
  parameter int SCREEN_COLS = 80
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    text_color,
  input  logic          q_valid,
  input  ttw_pkg::op_t  q_word,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [4:0]    cursor_row_out,
  output logic [6:0]    cursor_col_out,
  output logic [15:0]   cell_value,
  output logic          scrolled
);

  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 2 ** AW;
  localparam logic [RW-1:0] ROW_LAST = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(SCREEN_COLS - 1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_READ   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_FLUSH  = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t             state;
  logic [RW-1:0]      row;
  logic [CW-1:0]      col;
  logic [RW-1:0]      srow;
  logic [CW-1:0]      scol;
  logic [RW-1:0]      prow;
  logic [CW-1:0]      pcol;
  logic               pv;
  logic [1:0]         rep;
  logic               sc;
  logic [15:0]        rd_cell;
  ttw_pkg::op_kind_t  cur_kind;
  logic [7:0]         cur_ch;
  logic [4:0]         cur_row_in;
  logic [6:0]         cur_col_in;
  logic [RW-1:0]      row_cl;
  logic [CW-1:0]      col_cl;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [15:0]        ram_rdata;
  logic               out_load;

  ttw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign row_cl = ({2'b00, cur_row_in} >= 7'(SCREEN_ROWS)) ? ROW_LAST : RW'(cur_row_in);
  assign col_cl = ({1'b0, cur_col_in} >= 8'(SCREEN_COLS)) ? COL_LAST : CW'(cur_col_in);
  assign q_pop  = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {row, col};
    ram_wdata = {text_color, cur_ch};
    ram_raddr = {srow, scol};
    case (state)
      S_EXEC: begin
        if (cur_kind == ttw_pkg::OP_PUT) begin
          ram_we = 1'b1;
        end else if (cur_kind == ttw_pkg::OP_BACKSPACE && col != '0) begin
          ram_we    = 1'b1;
          ram_waddr = {row, col - CW'(1)};
          ram_wdata = {text_color, ttw_pkg::CH_SPACE};
        end else if (cur_kind == ttw_pkg::OP_READ) begin
          ram_raddr = {row_cl, col_cl};
        end
      end
      S_SCROLL: begin
        ram_we    = pv;
        ram_waddr = {prow, pcol};
        ram_wdata = ram_rdata;
      end
      S_FLUSH: begin
        ram_we    = 1'b1;
        ram_waddr = {prow, pcol};
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = {srow, scol};
        ram_wdata = {text_color, ttw_pkg::CH_SPACE};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_row_in <= q_word.row_in;
            cur_col_in <= q_word.col_in;
            sc         <= 1'b0;
            rd_cell    <= '0;
            if (q_word.kind == ttw_pkg::OP_TAB) begin
              cur_kind <= ttw_pkg::OP_PUT;
              cur_ch   <= ttw_pkg::CH_SPACE;
              rep      <= ttw_pkg::TAB_EXTRA;
            end else begin
              cur_kind <= q_word.kind;
              cur_ch   <= q_word.char_code;
              rep      <= 2'd0;
            end
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cur_kind)
            ttw_pkg::OP_PUT: begin
              if (col == COL_LAST && row == ROW_LAST) begin
                col   <= '0;
                sc    <= 1'b1;
                srow  <= RW'(1);
                scol  <= '0;
                pv    <= 1'b0;
                state <= S_SCROLL;
              end else begin
                if (col == COL_LAST) begin
                  col <= '0;
                  row <= row + RW'(1);
                end else begin
                  col <= col + CW'(1);
                end
                if (rep != 2'd0) begin
                  rep   <= rep - 2'd1;
                  state <= S_EXEC;
                end else begin
                  state <= S_DONE;
                end
              end
            end
            ttw_pkg::OP_NEWLINE: begin
              col <= '0;
              if (row == ROW_LAST) begin
                sc    <= 1'b1;
                srow  <= RW'(1);
                scol  <= '0;
                pv    <= 1'b0;
                state <= S_SCROLL;
              end else begin
                row   <= row + RW'(1);
                state <= S_DONE;
              end
            end
            ttw_pkg::OP_BACKSPACE: begin
              if (col != '0) begin
                col <= col - CW'(1);
              end
              state <= S_DONE;
            end
            ttw_pkg::OP_CLEAR: begin
              row   <= '0;
              col   <= '0;
              srow  <= '0;
              scol  <= '0;
              state <= S_FILL;
            end
            ttw_pkg::OP_SET: begin
              row   <= row_cl;
              col   <= col_cl;
              state <= S_DONE;
            end
            ttw_pkg::OP_READ: begin
              state <= S_READ;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          rd_cell <= ram_rdata;
          state   <= S_DONE;
        end
        S_SCROLL: begin
          pv   <= 1'b1;
          prow <= srow - RW'(1);
          pcol <= scol;
          if (scol == COL_LAST) begin
            scol <= '0;
            if (srow == ROW_LAST) begin
              state <= S_FLUSH;
            end else begin
              srow <= srow + RW'(1);
            end
          end else begin
            scol <= scol + CW'(1);
          end
        end
        S_FLUSH: begin
          srow  <= ROW_LAST;
          scol  <= '0;
          state <= S_FILL;
        end
        S_FILL: begin
          if (scol == COL_LAST) begin
            scol <= '0;
            if (srow == ROW_LAST) begin
              if (cur_kind == ttw_pkg::OP_CLEAR) begin
                state <= S_DONE;
              end else if (rep != 2'd0) begin
                rep   <= rep - 2'd1;
                state <= S_EXEC;
              end else begin
                state <= S_DONE;
              end
            end else begin
              srow <= srow + RW'(1);
            end
          end else begin
            scol <= scol + CW'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            cursor_row_out <= 5'(row);
            cursor_col_out <= 7'(col);
            cell_value     <= rd_cell;
            scrolled       <= sc;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/text_mode_terminal_writer_tb.sv]
`timescale 1ns / 100ps

module text_mode_terminal_writer_tb;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam int TAB_STOPS = 4;
  localparam int PHASE_WORDS = 210;
  localparam logic [2:0] TEXT_COLOR_ADDR = 3'(4 * ttw_pkg::REG_TEXT_COLOR);

  typedef struct {
    ttw_pkg::cmd_t cmd;
    logic [7:0]    ch;
    logic [4:0]    row;
    logic [6:0]    col;
  } word_t;

  typedef struct {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [15:0] value;
    logic        scrolled;
  } result_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_stall;
  ttw_pkg::cmd_t cmd = ttw_pkg::CMD_PUT;
  logic [7:0]    char_code = '0;
  logic [4:0]    row_in = '0;
  logic [6:0]    col_in = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [4:0]    cursor_row_out;
  logic [6:0]    cursor_col_out;
  logic [15:0]   cell_value;
  logic          scrolled;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  text_mode_terminal_writer #(
    .SCREEN_ROWS(ROWS),
    .SCREEN_COLS(COLS)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .char_code(char_code), .row_in(row_in), .col_in(col_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .cursor_row_out(cursor_row_out), .cursor_col_out(cursor_col_out),
    .cell_value(cell_value), .scrolled(scrolled),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Screen image and cursor as the block should hold them
  logic [15:0] cells [ROWS*COLS];
  int          crow = 0;
  int          ccol = 0;
  logic [7:0]  color = ttw_pkg::TEXT_COLOR_RESET;

  word_t   pending_cmds[$];
  result_t pending_results[$];
  bit      idle_on = 1'b1;
  bit      in_took = 1'b0;
  int      in_gap = 0;
  int      out_gap = 0;
  int      fails = 0;
  int      n_words = 0;
  int      n_reads = 0;
  int      n_clears = 0;
  int      n_scrolls = 0;
  int      n_colors = 0;

  function automatic bit line_feed();
    ccol = 0;
    crow++;
    if (crow >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
      for (int x = 0; x < COLS; x++) cells[(ROWS - 1) * COLS + x] = {color, ttw_pkg::CH_SPACE};
      crow = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit place_glyph(logic [7:0] ch);
    cells[crow * COLS + ccol] = {color, ch};
    ccol++;
    if (ccol >= COLS) return line_feed();
    return 1'b0;
  endfunction

  function automatic result_t screen_apply(word_t w);
    result_t res;
    int      r;
    int      c;
    res.value = '0;
    res.scrolled = 1'b0;
    r = (w.row >= ROWS) ? ROWS - 1 : w.row;
    c = (w.col >= COLS) ? COLS - 1 : w.col;
    case (w.cmd)
      ttw_pkg::CMD_PUT: begin
        case (w.ch)
          ttw_pkg::CH_NEWLINE: res.scrolled = line_feed();
          ttw_pkg::CH_BACKSPACE: begin
            if (ccol > 0) begin
              ccol--;
              cells[crow * COLS + ccol] = {color, ttw_pkg::CH_SPACE};
            end
          end
          ttw_pkg::CH_TAB: begin
            for (int i = 0; i < TAB_STOPS; i++)
              if (place_glyph(ttw_pkg::CH_SPACE)) res.scrolled = 1'b1;
          end
          default: res.scrolled = place_glyph(w.ch);
        endcase
      end
      ttw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < ROWS * COLS; i++) cells[i] = {color, ttw_pkg::CH_SPACE};
        crow = 0;
        ccol = 0;
      end
      ttw_pkg::CMD_SET: begin
        crow = r;
        ccol = c;
      end
      default: res.value = cells[r * COLS + c];
    endcase
    res.row = crow[4:0];
    res.col = ccol[6:0];
    return res;
  endfunction

  function automatic void push_word(ttw_pkg::cmd_t c, logic [7:0] ch, logic [4:0] r,
                                    logic [6:0] cl);
    word_t w;
    w.cmd = c;
    w.ch = ch;
    w.row = r;
    w.col = cl;
    pending_cmds.push_back(w);
  endfunction

  // Mostly text with line control, some cursor moves, reads and rare clears
  function automatic void push_random_word();
    int k;
    int j;
    k = $urandom_range(0, 99);
    j = $urandom_range(0, 9);
    if (k < 2)
      push_word(ttw_pkg::CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    else if (k < 12)
      push_word(ttw_pkg::CMD_SET, 8'($urandom),
                5'(($urandom_range(0, 2) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 31)),
                7'($urandom_range(0, 127)));
    else if (k < 24)
      push_word(ttw_pkg::CMD_READ, 8'($urandom), 5'($urandom_range(0, 31)),
                7'($urandom_range(0, 127)));
    else if (j == 0)
      push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_NEWLINE, 5'($urandom), 7'($urandom));
    else if (j == 1)
      push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_BACKSPACE, 5'($urandom), 7'($urandom));
    else if (j == 2)
      push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_TAB, 5'($urandom), 7'($urandom));
    else
      push_word(ttw_pkg::CMD_PUT, 8'($urandom_range(0, 255)), 5'($urandom), 7'($urandom));
  endfunction

  // Input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap == 0 && idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
      if (in_gap != 0 || pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap != 0) in_gap--;
      end else begin
        word_t w;
        w = pending_cmds.pop_front();
        cmd <= w.cmd;
        char_code <= w.ch;
        row_in <= w.row;
        col_in <= w.col;
        in_valid <= 1'b1;
      end
    end
  end

  // Result stall
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each accepted word, check each accepted result
  always @(posedge clk) begin
    word_t   w;
    result_t want;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        w.cmd = cmd;
        w.ch = char_code;
        w.row = row_in;
        w.col = col_in;
        want = screen_apply(w);
        pending_results.push_back(want);
        n_words++;
        if (w.cmd == ttw_pkg::CMD_READ) n_reads++;
        if (w.cmd == ttw_pkg::CMD_CLEAR) n_clears++;
        if (want.scrolled) n_scrolls++;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result arrived with none pending");
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (cursor_row_out !== want.row) begin
            $error("cursor_row_out: expected %0d, got %0d", want.row, cursor_row_out);
            fails++;
          end
          if (cursor_col_out !== want.col) begin
            $error("cursor_col_out: expected %0d, got %0d", want.col, cursor_col_out);
            fails++;
          end
          if (cell_value !== want.value) begin
            $error("cell_value: expected %04h, got %04h", want.value, cell_value);
            fails++;
          end
          if (scrolled !== want.scrolled) begin
            $error("scrolled: expected %0b, got %0b", want.scrolled, scrolled);
            fails++;
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_text_color();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = TEXT_COLOR_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== color) begin
      $error("text_color: expected %02h, got %02h", color, prdata[7:0]);
      fails++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_text_color(logic [7:0] c);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = TEXT_COLOR_ADDR;
    pwdata = {24'd0, c};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    color = c;
    n_colors++;
    check_text_color();
  endtask

  initial begin
    logic [7:0] palette [5];
    palette[0] = 8'h00;
    palette[1] = 8'hFF;
    palette[2] = 8'($urandom);
    palette[3] = 8'h1E;
    palette[4] = 8'($urandom);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_text_color();

    // directed: clear first so no cell is read before it is written
    push_word(ttw_pkg::CMD_CLEAR, 8'h00, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_PUT, 8'h41, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_PUT, 8'h00, 5'd31, 7'd127);
    push_word(ttw_pkg::CMD_PUT, 8'hFF, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_READ, 8'h00, 5'd0, 7'd2);
    push_word(ttw_pkg::CMD_SET, 8'h00, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_BACKSPACE, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_TAB, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_SET, 8'h00, 5'd0, 7'd78);
    push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_TAB, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_SET, 8'h00, 5'd0, 7'd79);
    push_word(ttw_pkg::CMD_PUT, 8'h7E, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_SET, 8'h00, 5'd31, 7'd127);
    push_word(ttw_pkg::CMD_PUT, 8'h5A, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_SET, 8'h00, 5'd24, 7'd77);
    push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_TAB, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_SET, 8'h00, 5'd24, 7'd5);
    push_word(ttw_pkg::CMD_PUT, ttw_pkg::CH_NEWLINE, 5'd0, 7'd0);
    push_word(ttw_pkg::CMD_READ, 8'h00, 5'd31, 7'd127);
    push_word(ttw_pkg::CMD_READ, 8'h00, 5'd22, 7'd0);
    push_word(ttw_pkg::CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
    push_word(ttw_pkg::CMD_READ, 8'h00, 5'd24, 7'd79);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_text_color(palette[p]);
      idle_on = (p != 4);
      repeat (PHASE_WORDS) push_random_word();
      drain();
    end

    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      fails++;
    end
    $display("Ran %0d commands: %0d cell reads, %0d clears, %0d scrolling commands,",
             n_words, n_reads, n_clears, n_scrolls);
    $display("across %0d written text colors plus the reset color.", n_colors);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
